@@ design/bplru_pkg.sv @@
// Shared constants and codes for the buffer pool frame table.
`timescale 1ns / 1ps
`default_nettype none
package bplru_pkg;

    // Fixed field widths
    localparam int TAG_W    = 31;
    localparam int PAGE_W   = 32;
    localparam int STATUS_W = 3;
    localparam int FI_W     = 4;
    localparam int CFG_W    = 5;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    // Register map: index is paddr[2]
    localparam logic REG_FRAMES_IN_USE = 1'b0;
    localparam logic [CFG_W-1:0] FRAMES_IN_USE_RESET = 5'd16;

    // Request codes
    localparam logic FUNC_GET   = 1'b0;
    localparam logic FUNC_UNPIN = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_HIT         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_LOAD_FREE   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_LOAD_EVICT  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ALL_PINNED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_INVALID     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_UNPINNED    = 3'd5;
    localparam logic [STATUS_W-1:0] ST_UNPIN_ABSENT = 3'd6;

    // Update commands broadcast to the frame cells
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_NONE       = 3'd0;
    localparam logic [OP_W-1:0] OP_UNPIN      = 3'd1;
    localparam logic [OP_W-1:0] OP_HIT        = 3'd2;
    localparam logic [OP_W-1:0] OP_LOAD_FREE  = 3'd3;
    localparam logic [OP_W-1:0] OP_LOAD_EVICT = 3'd4;

endpackage
`default_nettype wire

@@ design/bplru_cell.sv @@
// One frame cell: holds a frame's state, scans a passing packet, applies updates.
`timescale 1ns / 1ps
`default_nettype none
module bplru_cell
    import bplru_pkg::*;
#(
    parameter int FRAMES   = 16,
    parameter int PIN_BITS = 8,
    parameter int CELL_IDX = 0
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [CFG_W-1:0]     frames_in_use,
    input  wire logic [TAG_W-1:0]     req_tag,
    input  wire logic [OP_W+2*$clog2(FRAMES)+1-1:0] cmd,
    input  wire logic [4+3*$clog2(FRAMES)+2*$clog2(FRAMES)+TAG_W+1-1:0] pkt_in,
    output logic      [4+3*$clog2(FRAMES)+2*$clog2(FRAMES)+TAG_W+1-1:0] pkt_out
);

    localparam int IDX_W = $clog2(FRAMES);
    localparam int CW    = (IDX_W + 1 > CFG_W) ? IDX_W + 1 : CFG_W;

    typedef struct packed {
        logic             active;
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic [IDX_W-1:0] hit_rank;
        logic             free;
        logic [IDX_W-1:0] open_idx;
        logic             vic;
        logic [IDX_W-1:0] vic_idx;
        logic [IDX_W-1:0] vic_rank;
        logic [TAG_W-1:0] vic_tag;
        logic             vic_dirty;
    } pkt_t;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] slot;
        logic [IDX_W-1:0] rank;
        logic             dirty;
    } cmd_t;

    pkt_t pkt_i;
    cmd_t cmd_i;
    assign pkt_i = pkt_in;
    assign cmd_i = cmd;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic                valid_reg, valid_next;
    logic [TAG_W-1:0]    tag_reg, tag_next;
    logic [PIN_BITS-1:0] pins_reg, pins_next;
    logic                dirty_reg, dirty_next;
    logic [IDX_W-1:0]    rank_reg, rank_next;
    pkt_t                pkt_out_reg, pkt_out_next;
    logic                usable;
    logic                mine;

    assign usable = CW'(CELL_IDX) < CW'(frames_in_use);
    assign mine   = cmd_i.slot == MY_IDX;

    // Scan: fold this frame into the packet moving down the chain
    always_comb
    begin
        pkt_out_next = pkt_i;
        if (pkt_i.active)
        begin
            if (!pkt_i.hit && valid_reg && tag_reg == req_tag)
            begin
                pkt_out_next.hit      = 1'b1;
                pkt_out_next.hit_idx  = MY_IDX;
                pkt_out_next.hit_rank = rank_reg;
            end
            if (!pkt_i.free && !valid_reg && usable)
            begin
                pkt_out_next.free     = 1'b1;
                pkt_out_next.open_idx = MY_IDX;
            end
            // oldest unpinned usable frame; first one wins on a tie
            if (valid_reg && pins_reg == '0 && usable &&
                (!pkt_i.vic || rank_reg > pkt_i.vic_rank))
            begin
                pkt_out_next.vic       = 1'b1;
                pkt_out_next.vic_idx   = MY_IDX;
                pkt_out_next.vic_rank  = rank_reg;
                pkt_out_next.vic_tag   = tag_reg;
                pkt_out_next.vic_dirty = dirty_reg;
            end
        end
    end

    // Update: apply the broadcast command to this frame
    always_comb
    begin
        valid_next = valid_reg;
        tag_next   = tag_reg;
        pins_next  = pins_reg;
        dirty_next = dirty_reg;
        rank_next  = rank_reg;
        unique case (cmd_i.op) inside
            OP_UNPIN:
            begin
                if (mine)
                begin
                    if (pins_reg != '0)
                    begin
                        pins_next = pins_reg - PIN_BITS'(1);
                    end
                    dirty_next = dirty_reg | cmd_i.dirty;
                end
            end
            OP_HIT, OP_LOAD_EVICT:
            begin
                if (mine)
                begin
                    if (cmd_i.op == OP_HIT)
                    begin
                        if (pins_reg != '1)
                        begin
                            pins_next = pins_reg + PIN_BITS'(1);
                        end
                    end
                    else
                    begin
                        valid_next = 1'b1;
                        tag_next   = req_tag;
                        pins_next  = PIN_BITS'(1);
                        dirty_next = 1'b0;
                    end
                    rank_next = '0;
                end
                else if (valid_reg && rank_reg < cmd_i.rank)
                begin
                    rank_next = rank_reg + IDX_W'(1);
                end
            end
            OP_LOAD_FREE:
            begin
                if (mine)
                begin
                    valid_next = 1'b1;
                    tag_next   = req_tag;
                    pins_next  = PIN_BITS'(1);
                    dirty_next = 1'b0;
                    rank_next  = '0;
                end
                else if (valid_reg)
                begin
                    rank_next = rank_reg + IDX_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // Frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            pins_reg    <= '0;
            dirty_reg   <= 1'b0;
            rank_reg    <= '0;
            pkt_out_reg <= '0;
        end
        else
        begin
            valid_reg   <= valid_next;
            pins_reg    <= pins_next;
            dirty_reg   <= dirty_next;
            rank_reg    <= rank_next;
            pkt_out_reg <= pkt_out_next;
        end
    end

    // Tag is only read while the frame is valid
    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
    end

    assign pkt_out = pkt_out_reg;

endmodule
`default_nettype wire

@@ design/buffer_pool_lru_pin_manager.sv @@
// Top level of the buffer pool frame table: request control, config port, cell chain.
//
//  channel   | signals                                        | handshake
//  ----------+------------------------------------------------+---------------------------
//  request   | func, page_number, mark_dirty                  | taken when start && !busy
//  result    | status, frame_index, load_needed,              | shown for one cycle with
//            | writeback_needed, writeback_page               | done; cannot be held off
//  config    | psel, penable, pwrite, paddr, pwdata, prdata   | APB, pready tied high
//
// For each item a search packet walks the frame cells one per cycle, the result is
// decided from the last cell, and the update is broadcast to all cells in the cycle
// the result is shown. busy is high for the whole item.
// Reset is asynchronous: all frames empty, frames_in_use back to 16.
// The result side has no stall.
`timescale 1ns / 1ps
`default_nettype none
module buffer_pool_lru_pin_manager
    import bplru_pkg::*;
#(
    parameter int FRAMES   = 16,
    parameter int PIN_BITS = 8
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic                    func,
    input  wire logic signed [PAGE_W-1:0] page_number,
    input  wire logic                    mark_dirty,
    output logic                         done,
    output logic [STATUS_W-1:0]          status,
    output logic [FI_W-1:0]              frame_index,
    output logic                         load_needed,
    output logic                         writeback_needed,
    output logic [TAG_W-1:0]             writeback_page,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [ADDR_W-1:0]       paddr,
    input  wire logic [DATA_W-1:0]       pwdata,
    output logic [DATA_W-1:0]            prdata,
    output logic                         pready
);

    localparam int IDX_W = $clog2(FRAMES);

    typedef struct packed {
        logic             active;
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic [IDX_W-1:0] hit_rank;
        logic             free;
        logic [IDX_W-1:0] open_idx;
        logic             vic;
        logic [IDX_W-1:0] vic_idx;
        logic [IDX_W-1:0] vic_rank;
        logic [TAG_W-1:0] vic_tag;
        logic             vic_dirty;
    } pkt_t;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] slot;
        logic [IDX_W-1:0] rank;
        logic             dirty;
    } cmd_t;

    logic                 busy_reg, busy_next;
    logic                 inject_reg;
    logic                 func_reg;
    logic                 neg_reg;
    logic                 dirty_in_reg;
    logic [TAG_W-1:0]     tag_reg;
    logic [CFG_W-1:0]     frames_in_use_reg;
    cmd_t                 cmd_reg, cmd_next;
    logic                 done_reg;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [IDX_W-1:0]     findex_reg, findex_next;
    logic                 load_reg, load_next;
    logic                 wb_reg, wb_next;
    logic [TAG_W-1:0]     wbpage_reg, wbpage_next;
    logic                 accept;
    logic                 cfg_write;
    pkt_t                 inject_pkt;
    pkt_t                 last_pkt;
    pkt_t                 chain [0:FRAMES];

    assign accept    = start && !busy_reg;
    assign cfg_write = psel && penable && pwrite && pready;

    // Empty packet launched into the first cell
    always_comb
    begin
        inject_pkt        = '0;
        inject_pkt.active = inject_reg;
    end

    assign chain[0] = inject_pkt;
    assign last_pkt = chain[FRAMES];

    // Row of frame cells
    for (genvar g = 0; g < FRAMES; g++)
    begin : g_cell
        bplru_cell #(
            .FRAMES   (FRAMES),
            .PIN_BITS (PIN_BITS),
            .CELL_IDX (g)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .frames_in_use (frames_in_use_reg),
            .req_tag       (tag_reg),
            .cmd           (cmd_reg),
            .pkt_in        (chain[g]),
            .pkt_out       (chain[g+1])
        );
    end

    // Decide the result from the packet leaving the last cell
    always_comb
    begin
        status_next = ST_ALL_PINNED;
        findex_next = '0;
        load_next   = 1'b0;
        wb_next     = 1'b0;
        wbpage_next = '0;
        cmd_next    = '0;
        cmd_next.op = OP_NONE;
        if (func_reg == FUNC_UNPIN)
        begin
            if (last_pkt.hit && !neg_reg)
            begin
                status_next    = ST_UNPINNED;
                findex_next    = last_pkt.hit_idx;
                cmd_next.op    = OP_UNPIN;
                cmd_next.slot  = last_pkt.hit_idx;
                cmd_next.dirty = dirty_in_reg;
            end
            else
            begin
                status_next = ST_UNPIN_ABSENT;
            end
        end
        else if (neg_reg)
        begin
            status_next = ST_INVALID;
        end
        else if (last_pkt.hit)
        begin
            status_next   = ST_HIT;
            findex_next   = last_pkt.hit_idx;
            cmd_next.op   = OP_HIT;
            cmd_next.slot = last_pkt.hit_idx;
            cmd_next.rank = last_pkt.hit_rank;
        end
        else if (last_pkt.free)
        begin
            status_next   = ST_LOAD_FREE;
            findex_next   = last_pkt.open_idx;
            load_next     = 1'b1;
            cmd_next.op   = OP_LOAD_FREE;
            cmd_next.slot = last_pkt.open_idx;
        end
        else if (last_pkt.vic)
        begin
            status_next   = ST_LOAD_EVICT;
            findex_next   = last_pkt.vic_idx;
            load_next     = 1'b1;
            wb_next       = last_pkt.vic_dirty;
            wbpage_next   = last_pkt.vic_dirty ? last_pkt.vic_tag : '0;
            cmd_next.op   = OP_LOAD_EVICT;
            cmd_next.slot = last_pkt.vic_idx;
            cmd_next.rank = last_pkt.vic_rank;
        end
        // no update unless the search packet has just arrived
        if (!last_pkt.active)
        begin
            cmd_next    = '0;
            cmd_next.op = OP_NONE;
        end
    end

    // Busy from accept until the update has been applied
    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (done_reg)
        begin
            busy_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg          <= 1'b0;
            inject_reg        <= 1'b0;
            done_reg          <= 1'b0;
            cmd_reg           <= '0;
            frames_in_use_reg <= FRAMES_IN_USE_RESET;
        end
        else
        begin
            busy_reg   <= busy_next;
            inject_reg <= accept;
            done_reg   <= last_pkt.active;
            cmd_reg    <= cmd_next;
            if (cfg_write && paddr[2] == REG_FRAMES_IN_USE)
            begin
                frames_in_use_reg <= pwdata[CFG_W-1:0];
            end
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg     <= func;
            neg_reg      <= page_number[PAGE_W-1];
            tag_reg      <= page_number[TAG_W-1:0];
            dirty_in_reg <= mark_dirty;
        end
        if (last_pkt.active)
        begin
            status_reg <= status_next;
            findex_reg <= findex_next;
            load_reg   <= load_next;
            wb_reg     <= wb_next;
            wbpage_reg <= wbpage_next;
        end
    end

    // Register read
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_FRAMES_IN_USE)
        begin
            prdata = DATA_W'(frames_in_use_reg);
        end
    end

    assign pready           = 1'b1;
    assign busy             = busy_reg;
    assign done             = done_reg;
    assign status           = status_reg;
    assign frame_index      = FI_W'(findex_reg);
    assign load_needed      = load_reg;
    assign writeback_needed = wb_reg;
    assign writeback_page   = wbpage_reg;

endmodule
`default_nettype wire

@@ design/bplru_checker.sv @@
// Port-level checks for the buffer pool frame table, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module bplru_checker
    import bplru_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic                busy,
    input  wire logic                done,
    input  wire logic [STATUS_W-1:0] status,
    input  wire logic                load_needed,
    input  wire logic                writeback_needed
);

    // A result only shows up while an item is in progress
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe without an item in progress");

    // An accepted item holds busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // Exactly one result per item: the item ends right after its result
    a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done && !busy))
        else $error("item did not end after its result");

    // Loads only come with a load status
    a_load_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && load_needed) |-> (status == ST_LOAD_FREE || status == ST_LOAD_EVICT))
        else $error("load request with wrong status");

    // Write-back only after an eviction
    a_wb_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && writeback_needed) |-> (status == ST_LOAD_EVICT && load_needed))
        else $error("write-back without eviction");

endmodule

bind buffer_pool_lru_pin_manager bplru_checker u_bplru_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .done             (done),
    .status           (status),
    .load_needed      (load_needed),
    .writeback_needed (writeback_needed)
);
`default_nettype wire
